// ----- hw/rtl/plpe_pkg.sv -----
// Package for the piecewise-linear profile evaluator.
// Word types, request and status codes, table sizing. No dependencies.
`default_nettype none
package plpe_pkg;
    localparam int KNOTS = 64;
    localparam int IDX_W = 6;
    localparam int CNT_W = 7;

    localparam logic [1:0] REQ_LOAD = 2'd0;
    localparam logic [1:0] REQ_EVAL = 2'd1;
    localparam logic [1:0] REQ_INTG = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ORDER = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [5:0]         knot_index;
        logic signed [31:0] time_a;
        logic signed [31:0] time_b;
        logic [31:0]        knot_rate;
    } in_word_t;

    typedef struct packed {
        logic signed [63:0] result_value;
        logic [1:0]         status;
    } out_word_t;

    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [32:0] den;
    } div_req_t;
endpackage
`default_nettype wire

// ----- hw/rtl/plpe_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on plpe_pkg for the request struct.
`default_nettype none
module plpe_div (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire plpe_pkg::div_req_t req,
    output logic                   done,
    output logic [63:0]            quot
);
    import plpe_pkg::*;
    logic [63:0] q_reg, q_next;
    logic [33:0] r_reg, r_next;
    logic [32:0] d_reg, d_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next, done_reg, done_next;
    logic [33:0] sh;
    logic [34:0] diff;

    always_comb begin
        q_next = q_reg; r_next = r_reg; d_next = d_reg; cnt_next = cnt_reg;
        busy_next = busy_reg; done_next = 1'b0;
        sh = {r_reg[32:0], q_reg[63]};
        diff = {1'b0, sh} - {2'b0, d_reg};
        if (req.start) begin
            q_next = req.num; r_next = '0; d_next = req.den;
            cnt_next = 7'd64; busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!diff[34]) begin
                r_next = diff[33:0];
                q_next = {q_reg[62:0], 1'b1};
            end else begin
                r_next = sh;
                q_next = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                busy_next = 1'b0; done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next; r_reg <= r_next; d_reg <= d_next; cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0; done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next; done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign quot = q_reg;
endmodule
`default_nettype wire

// ----- hw/rtl/piecewise_linear_profile_eval_core.sv -----
// Piecewise-linear profile evaluator: knot table, interpolation, trapezoid integral.
// Load checks order against the previous knot (index 0 is written unchecked); evaluate
// scans knots, may divide; integrate walks up to n+1 segments of two evaluations and a
// split multiply. Speed is set by the linear knot scan, the divider and the read port.
// One word at a time; a registered result waits in the output register. Sync reset.
// Depends on plpe_pkg and plpe_div.
`default_nettype none
module piecewise_linear_profile_eval_core (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_we,
    input  wire logic [6:0]          cfg_wdata,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire plpe_pkg::in_word_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output plpe_pkg::out_word_t      m_data
);
    import plpe_pkg::*;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_LDRD  = 5'd1;
    localparam logic [4:0] S_LDCK  = 5'd2;
    localparam logic [4:0] S_IGSET = 5'd3;
    localparam logic [4:0] S_IGRD  = 5'd4;
    localparam logic [4:0] S_IGCK  = 5'd5;
    localparam logic [4:0] S_SEG   = 5'd6;
    localparam logic [4:0] S_EV0   = 5'd7;
    localparam logic [4:0] S_EV1   = 5'd8;
    localparam logic [4:0] S_EVSC  = 5'd9;
    localparam logic [4:0] S_EVCK  = 5'd10;
    localparam logic [4:0] S_EVLO  = 5'd11;
    localparam logic [4:0] S_EVLW  = 5'd12;
    localparam logic [4:0] S_EVMUL = 5'd13;
    localparam logic [4:0] S_EVDIV = 5'd14;
    localparam logic [4:0] S_EVWT  = 5'd15;
    localparam logic [4:0] S_EVFIN = 5'd16;
    localparam logic [4:0] S_MUL0  = 5'd17;
    localparam logic [4:0] S_MUL1  = 5'd18;
    localparam logic [4:0] S_MUL2  = 5'd19;
    localparam logic [4:0] S_FIN   = 5'd20;
    localparam logic [4:0] S_OUT   = 5'd21;
    localparam logic [4:0] S_EVA   = 5'd22;
    localparam logic [4:0] S_EVB   = 5'd23;

    logic [31:0] tmem [KNOTS];
    logic [31:0] rmem [KNOTS];
    logic [IDX_W-1:0] raddr;
    logic [31:0] rt_reg, rr_reg;
    logic        we;
    logic [IDX_W-1:0] waddr;
    in_word_t    in_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            tmem[waddr] <= in_reg.time_a;
            rmem[waddr] <= in_reg.knot_rate;
        end
        rt_reg <= tmem[raddr];
        rr_reg <= rmem[raddr];
    end

    logic [4:0] st_reg, st_next, ret_reg, ret_next;
    logic [CNT_W-1:0] kiu_reg;
    logic [IDX_W-1:0] n1;          // n-1
    logic [IDX_W-1:0] idx_reg, idx_next;   // integration knot walk
    logic [IDX_W-1:0] sidx_reg, sidx_next; // eval scan
    logic        idone_reg, idone_next;
    logic signed [32:0] lo_reg, lo_next, hi_reg, hi_next, prev_reg, prev_next;
    logic signed [32:0] seg_t1_reg, seg_t1_next;
    logic        neg_reg, neg_next;
    logic signed [32:0] evt_reg, evt_next;
    logic signed [32:0] tlo_reg, tlo_next, t0k_reg, t0k_next;
    logic [31:0] rlo_reg, rlo_next, r0k_reg, r0k_next;
    logic [32:0] v_reg, v_next, vsum_reg, vsum_next;
    logic [63:0] prod_reg, prod_next;
    logic        up_reg, up_next;
    logic [32:0] d_reg, d_next;
    logic [127:0] acc_reg, acc_next;
    logic [65:0] pacc_reg, pacc_next;
    logic [63:0] res_reg, res_next;
    logic [1:0]  sts_reg, sts_next;
    logic [63:0] ores_reg, ores_next;
    logic [1:0]  osts_reg, osts_next;
    logic        mv_reg, mv_next;
    div_req_t    dreq;
    logic        ddone;
    logic [63:0] dq;
    logic signed [32:0] rtx;
    logic [63:0] mulres;
    logic [31:0] ma;
    logic [31:0] mb;
    logic [127:0] acc1;
    logic [127:0] mag;

    plpe_div u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .done(ddone), .quot(dq));

    always_comb begin
        n1 = IDX_W'(kiu_reg - 7'd1);
        if (kiu_reg == 7'd0) n1 = '0;
        else if (kiu_reg > 7'(KNOTS)) n1 = IDX_W'(KNOTS - 1);
    end

    assign rtx = {rt_reg[31], rt_reg};
    assign mulres = ma * mb;
    assign acc1 = acc_reg + 128'd1;
    assign mag = {1'b0, acc1[127:1]};

    always_comb begin
        st_next = st_reg; ret_next = ret_reg; idx_next = idx_reg; sidx_next = sidx_reg;
        idone_next = idone_reg; lo_next = lo_reg; hi_next = hi_reg; prev_next = prev_reg;
        seg_t1_next = seg_t1_reg; neg_next = neg_reg; evt_next = evt_reg;
        tlo_next = tlo_reg; rlo_next = rlo_reg; t0k_next = t0k_reg; r0k_next = r0k_reg;
        v_next = v_reg; vsum_next = vsum_reg; prod_next = prod_reg;
        up_next = up_reg; d_next = d_reg; acc_next = acc_reg; pacc_next = pacc_reg;
        res_next = res_reg; sts_next = sts_reg; mv_next = mv_reg;
        ores_next = ores_reg; osts_next = osts_reg;
        raddr = '0; we = 1'b0; waddr = in_reg.knot_index;
        dreq.start = 1'b0; dreq.num = prod_reg; dreq.den = d_reg;
        ma = '0; mb = '0;
        if (mv_reg && m_ready) mv_next = 1'b0;
        case (st_reg)
            S_IDLE: ;
            S_LDRD: begin
                raddr = in_reg.knot_index - 6'd1;
                res_next = '0; sts_next = ST_OK;
                if (in_reg.knot_index == '0) begin
                    we = 1'b1; st_next = S_OUT;
                end else st_next = S_LDCK;
            end
            S_LDCK: begin
                if ($signed(in_reg.time_a) <= $signed(rt_reg)) sts_next = ST_ORDER;
                else we = 1'b1;
                st_next = S_OUT;
            end
            S_IGSET: begin
                sts_next = ST_OK; res_next = '0; acc_next = '0;
                if (in_reg.req_type == REQ_EVAL) begin
                    evt_next = {in_reg.time_a[31], in_reg.time_a};
                    ret_next = S_FIN; st_next = S_EV0;
                end else if (in_reg.req_type != REQ_INTG ||
                             in_reg.time_a == in_reg.time_b) begin
                    st_next = S_OUT;
                end else begin
                    neg_next = $signed(in_reg.time_b) < $signed(in_reg.time_a);
                    lo_next = neg_next ? {in_reg.time_b[31], in_reg.time_b}
                                       : {in_reg.time_a[31], in_reg.time_a};
                    hi_next = neg_next ? {in_reg.time_a[31], in_reg.time_a}
                                       : {in_reg.time_b[31], in_reg.time_b};
                    prev_next = lo_next; idx_next = '0; idone_next = 1'b0;
                    st_next = S_IGRD;
                end
            end
            S_IGRD: begin
                raddr = idx_reg; st_next = S_IGCK;
            end
            S_IGCK: begin
                if (idone_reg) begin
                    seg_t1_next = hi_reg; st_next = S_SEG;
                end else if (rtx > prev_reg && rtx < hi_reg) begin
                    seg_t1_next = rtx; st_next = S_SEG;
                end else begin
                    if (idx_reg == n1) idone_next = 1'b1;
                    else idx_next = idx_reg + 6'd1;
                    st_next = idone_next ? S_IGCK : S_IGRD;
                end
                if (st_next == S_SEG && !idone_reg) begin
                    if (idx_reg == n1) idone_next = 1'b1;
                    else idx_next = idx_reg + 6'd1;
                end
            end
            S_SEG: begin
                evt_next = prev_reg; ret_next = S_EVA; st_next = S_EV0;
            end
            S_EVA: begin
                vsum_next = v_reg; evt_next = seg_t1_reg; ret_next = S_EVB; st_next = S_EV0;
            end
            S_EVB: begin
                vsum_next = vsum_reg + v_reg; st_next = S_MUL0;
            end
            S_MUL0: begin
                // (t1-t0) fits 33 bits unsigned; vsum 33 bits: split into 32x32 pieces
                d_next = 33'(seg_t1_reg - prev_reg);
                st_next = S_MUL1;
            end
            S_MUL1: begin
                ma = vsum_reg[31:0]; mb = d_reg[31:0];
                pacc_next = {2'b0, mulres};
                prod_next = {32'b0, (vsum_reg[32] ? d_reg[31:0] : 32'b0)};
                st_next = S_MUL2;
            end
            S_MUL2: begin
                acc_next = acc_reg + {62'b0, pacc_reg}
                         + ({64'b0, prod_reg} << 32)
                         + (d_reg[32] ? ({95'b0, vsum_reg} << 32) : 128'b0);
                prev_next = seg_t1_reg;
                st_next = (seg_t1_reg == hi_reg) ? S_FIN : S_IGRD;
                if (seg_t1_reg != hi_reg && idone_reg) st_next = S_IGCK;
            end
            S_FIN: begin
                if (in_reg.req_type == REQ_EVAL) begin
                    res_next = {31'b0, v_reg};
                end else if (!neg_reg) begin
                    if (mag[127:63] != '0) begin
                        res_next = 64'h7FFF_FFFF_FFFF_FFFF; sts_next = ST_SAT;
                    end else res_next = mag[63:0];
                end else begin
                    if (mag[127:64] != '0 || mag[63:0] > 64'h8000_0000_0000_0000) begin
                        res_next = 64'h8000_0000_0000_0000; sts_next = ST_SAT;
                    end else res_next = 64'd0 - mag[63:0];
                end
                st_next = S_OUT;
            end
            // rate evaluation at evt_reg, result in v_reg, returns to ret_reg
            S_EV0: begin
                raddr = '0; st_next = S_EV1;
            end
            S_EV1: begin
                raddr = n1; t0k_next = rtx; r0k_next = rr_reg;
                if (evt_reg <= rtx) begin
                    v_next = {1'b0, rr_reg}; st_next = ret_reg;
                end else st_next = S_EVSC;
            end
            S_EVSC: begin
                if (evt_reg >= rtx) begin
                    v_next = {1'b0, rr_reg}; st_next = ret_reg;
                end else begin
                    sidx_next = 6'd1; raddr = 6'd1; st_next = S_EVCK;
                end
            end
            S_EVCK: begin
                if (evt_reg < rtx) begin
                    raddr = sidx_reg - 6'd1;
                    tlo_next = rtx; rlo_next = rr_reg; st_next = S_EVLO;
                end else begin
                    sidx_next = sidx_reg + 6'd1; raddr = sidx_next;
                end
            end
            S_EVLO: begin
                // tlo/rlo hold hi knot; swap in lo knot
                d_next = 33'(tlo_reg - rtx);
                t0k_next = rtx; r0k_next = rr_reg;
                prod_next = {32'b0, rlo_reg}; st_next = S_EVLW;
            end
            S_EVLW: begin
                rlo_next = r0k_reg;
                if ($signed(d_reg) <= 0) begin
                    v_next = {1'b0, r0k_reg}; st_next = ret_reg;
                end else st_next = S_EVMUL;
            end
            S_EVMUL: begin
                up_next = prod_reg[31:0] >= rlo_reg;
                ma = 32'(evt_reg - t0k_reg);
                mb = up_next ? prod_reg[31:0] - rlo_reg : rlo_reg - prod_reg[31:0];
                prod_next = mulres + {32'b0, d_reg[32:1]};
                st_next = S_EVDIV;
            end
            S_EVDIV: begin
                dreq.start = 1'b1; st_next = S_EVWT;
            end
            S_EVWT: begin
                if (ddone) st_next = S_EVFIN;
            end
            S_EVFIN: begin
                v_next = up_reg ? {1'b0, rlo_reg} + dq[32:0] : {1'b0, rlo_reg} - dq[32:0];
                st_next = ret_reg;
            end
            S_OUT: begin
                if (!mv_reg || m_ready) begin
                    mv_next = 1'b1; st_next = S_IDLE;
                    ores_next = res_reg; osts_next = sts_reg;
                end
            end
            default: st_next = S_IDLE;
        endcase
        if (st_reg == S_IDLE && s_valid)
            st_next = (s_data.req_type == REQ_LOAD) ? S_LDRD : S_IGSET;
    end

    assign s_ready = (st_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) in_reg <= s_data;
        idx_reg <= idx_next; sidx_reg <= sidx_next; idone_reg <= idone_next;
        lo_reg <= lo_next; hi_reg <= hi_next; prev_reg <= prev_next;
        seg_t1_reg <= seg_t1_next; neg_reg <= neg_next; evt_reg <= evt_next;
        tlo_reg <= tlo_next; rlo_reg <= rlo_next; t0k_reg <= t0k_next; r0k_reg <= r0k_next;
        v_reg <= v_next; vsum_reg <= vsum_next;
        prod_reg <= prod_next; up_reg <= up_next; d_reg <= d_next;
        acc_reg <= acc_next; pacc_reg <= pacc_next; res_reg <= res_next;
        sts_reg <= sts_next; ret_reg <= ret_next;
        ores_reg <= ores_next; osts_reg <= osts_next;
        if (!aresetn) begin
            st_reg <= S_IDLE; mv_reg <= 1'b0; kiu_reg <= 7'd1;
        end else begin
            st_reg <= st_next; mv_reg <= mv_next;
            if (cfg_we) kiu_reg <= cfg_wdata;
        end
    end

    assign m_valid = mv_reg;
    assign m_data.result_value = ores_reg;
    assign m_data.status = osts_reg;
endmodule
`default_nettype wire
